/* rtl/jfse_pkg.sv */
// ----------------------------------------------------------------------------
// jfse_pkg
// Types and constants for the JPEG frame size extractor: parser phases,
// marker codes and field widths.
// ----------------------------------------------------------------------------
package jfse_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DimW    = 16;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned InUserW = 2;
  localparam int unsigned OutDataW = 2 * DimW;

  localparam logic [ByteW-1:0] MarkPrefix = 8'hFF;
  localparam logic [ByteW-1:0] MarkSoi    = 8'hD8;
  localparam logic [ByteW-1:0] MarkEoi    = 8'hD9;
  localparam logic [ByteW-1:0] MarkSos    = 8'hDA;
  localparam logic [ByteW-1:0] MarkDht    = 8'hC4;
  localparam logic [ByteW-1:0] MarkJpg    = 8'hC8;
  localparam logic [ByteW-1:0] MarkDac    = 8'hCC;
  localparam logic [3:0]       SofNibble  = 4'hC;

  // frame header byte positions after the marker code
  localparam logic [IdxW-1:0] IdxHeightHi = 3'd3;
  localparam logic [IdxW-1:0] IdxHeightLo = 3'd4;
  localparam logic [IdxW-1:0] IdxWidthHi  = 3'd5;
  localparam logic [IdxW-1:0] IdxWidthLo  = 3'd6;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  typedef enum logic [8:0] {
    PH_SOI0  = 9'b0_0000_0001,
    PH_SOI1  = 9'b0_0000_0010,
    PH_SEEK  = 9'b0_0000_0100,
    PH_MARK  = 9'b0_0000_1000,
    PH_LENHI = 9'b0_0001_0000,
    PH_LENLO = 9'b0_0010_0000,
    PH_SKIP  = 9'b0_0100_0000,
    PH_FRAME = 9'b0_1000_0000,
    PH_DONE  = 9'b1_0000_0000
  } phase_e;

  function automatic logic is_sof_marker(logic [ByteW-1:0] code);
    return (code[7:4] == SofNibble) && (code != MarkDht) &&
           (code != MarkJpg) && (code != MarkDac);
  endfunction

endpackage

/* rtl/jpeg_frame_size_extractor_unit.sv */
// ----------------------------------------------------------------------------
// jpeg_frame_size_extractor_unit
// Byte-wide JPEG marker parser: checks SOI, walks segments, reports the
// frame height and width from the start-of-frame header, or a bad status.
// ----------------------------------------------------------------------------
// Output: a result is registered and is on m_axis in the cycle after the byte that completes it.
// Throughput: one byte per cycle; the parser phase register updates on each
// transfer, and s_axis_tready drops only while a result waits on m_axis.
// Reset: asynchronous, active low; parser waits for the first SOI byte and
// the output register is empty.
module jpeg_frame_size_extractor_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [jfse_pkg::ByteW-1:0]        s_axis_tdata,  // byte_value
  input  logic [jfse_pkg::InUserW-1:0]      s_axis_tuser,  // start_of_file, end_of_stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [jfse_pkg::OutDataW-1:0]     m_axis_tdata,  // width, height
  output logic                              m_axis_tuser   // status
);
  import jfse_pkg::*;

  phase_e            phase_q, phase_d, phase_cur;
  logic [DimW-1:0]   skip_q, skip_d, skip_dec;
  logic [ByteW-1:0]  len_hi_q, len_hi_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [DimW-1:0]   height_q, height_d;
  logic [ByteW-1:0]  width_hi_q, width_hi_d;
  logic              out_valid_q, out_valid_d;
  logic [DimW-1:0]   out_width_q, out_width_d;
  logic [DimW-1:0]   out_height_q, out_height_d;
  logic              out_status_q, out_status_d;

  logic              in_fire, emit, emit_ok;
  logic              sof, eos;
  logic [ByteW-1:0]  b;
  logic [DimW-1:0]   seg_len;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign sof           = s_axis_tuser[0];
  assign eos           = s_axis_tuser[1];
  assign phase_cur     = sof ? PH_SOI0 : phase_q;
  assign seg_len       = {len_hi_q, b};
  assign skip_dec      = skip_q - DimW'(skip_q != '0);

  always_comb begin
    phase_d    = phase_q;
    skip_d     = skip_q;
    len_hi_d   = len_hi_q;
    idx_d      = idx_q;
    height_d   = height_q;
    width_hi_d = width_hi_q;
    emit       = 1'b0;
    emit_ok    = 1'b0;
    if (in_fire) begin
      phase_d = phase_cur;
      if (eos) begin
        emit = (phase_cur != PH_DONE);
      end else begin
        unique case (phase_cur)
          PH_SOI0: begin
            if (b != MarkPrefix) emit = 1'b1;
            else phase_d = PH_SOI1;
          end
          PH_SOI1: begin
            if (b != MarkSoi) emit = 1'b1;
            else phase_d = PH_SEEK;
          end
          PH_SEEK: begin
            if (b == MarkPrefix) phase_d = PH_MARK;
          end
          PH_MARK: begin
            if (b == MarkPrefix) begin
              phase_d = PH_MARK;
            end else if (b == MarkEoi || b == MarkSos) begin
              emit = 1'b1;
            end else if (is_sof_marker(b)) begin
              idx_d   = '0;
              phase_d = PH_FRAME;
            end else begin
              phase_d = PH_LENHI;
            end
          end
          PH_LENHI: begin
            len_hi_d = b;
            phase_d  = PH_LENLO;
          end
          PH_LENLO: begin
            if (seg_len[DimW-1:1] == '0) begin
              emit = 1'b1;
            end else begin
              skip_d  = seg_len - DimW'(2);
              phase_d = (seg_len == DimW'(2)) ? PH_SEEK : PH_SKIP;
            end
          end
          PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == '0) phase_d = PH_SEEK;
          end
          PH_FRAME: begin
            idx_d = idx_q + IdxW'(1);
            unique case (idx_q)
              IdxHeightHi: height_d   = {b, {ByteW{1'b0}}};
              IdxHeightLo: height_d   = {height_q[DimW-1:ByteW], b};
              IdxWidthHi:  width_hi_d = b;
              IdxWidthLo: begin
                idx_d   = '0;
                emit    = 1'b1;
                emit_ok = 1'b1;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      if (emit) phase_d = PH_DONE;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_width_d  = out_width_q;
    out_height_d = out_height_q;
    out_status_d = out_status_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_width_d  = emit_ok ? {width_hi_q, b} : '0;
      out_height_d = emit_ok ? height_q : '0;
      out_status_d = emit_ok ? StatusOk : StatusBad;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SOI0;
      skip_q      <= '0;
      len_hi_q    <= '0;
      idx_q       <= '0;
      height_q    <= '0;
      width_hi_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      skip_q      <= skip_d;
      len_hi_q    <= len_hi_d;
      idx_q       <= idx_d;
      height_q    <= height_d;
      width_hi_q  <= width_hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_width_q  <= out_width_d;
    out_height_q <= out_height_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_height_q, out_width_q};
  assign m_axis_tuser  = out_status_q;

  a_stall_only_on_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a held result");

  a_done_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (phase_q == PH_DONE && out_valid_q))
    else $error("result not registered or parser not finished");

  a_ok_only_from_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_ok |-> (phase_cur == PH_FRAME && idx_q == IdxWidthLo && !eos))
    else $error("dimensions reported outside the frame header");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (skip_q != '0))
    else $error("skip phase with empty count");

endmodule

/* tb/jpeg_frame_size_extractor_unit_tb.sv */
// ----------------------------------------------------------------------------
// jpeg_frame_size_extractor_unit_tb
// Self-checking bench for the JPEG frame size extractor. A queue of byte
// transfers (directed files, then random well-formed, broken and noise
// files) feeds a bursty stream driver. A local parser model predicts each
// dimension or bad-status result. A monitor with its own stall pattern,
// and one long hold-off, checks every result against the oldest prediction.
// ----------------------------------------------------------------------------
module jpeg_frame_size_extractor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jfse_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumItems   = 1200;

  typedef struct packed {
    logic [ByteW-1:0] val;
    logic             sof;
    logic             eos;
  } byte_item_t;

  typedef struct packed {
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    logic            st;
  } dims_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata = '0;   // byte_value
  logic [InUserW-1:0]  s_axis_tuser = '0;   // start_of_file, end_of_stream
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // width, height
  logic                m_axis_tuser;        // status

  byte_item_t byte_q[$];
  dims_t      dims_q[$];
  byte_item_t cur_item;
  int         errors = 0;
  int         gap_left = 0;
  int         burst_left = 1;
  int         stall_pct = 0;
  int         stall_timer = 0;
  int         hold_cnt = 0;
  int         cycle_cnt = 0;
  logic       hold_off;

  // parser model state
  phase_e          phase_q = PH_SOI0;
  logic [DimW-1:0] skip_left = '0;
  logic [ByteW-1:0] len_hi = '0;
  logic [IdxW-1:0] hdr_idx = '0;
  logic [DimW-1:0] height_acc_q = '0;
  logic [ByteW-1:0] width_hi = '0;

  jpeg_frame_size_extractor_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic frame_code(logic [ByteW-1:0] code);
    return (code[7:4] == SofNibble) && (code != MarkDht) &&
           (code != MarkJpg) && (code != MarkDac);
  endfunction

  task automatic report_dims(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                             input logic st);
    dims_t d;
    d.w = w;
    d.h = h;
    d.st = st;
    dims_q.push_back(d);
    phase_q = PH_DONE;
  endtask

  task automatic predict_dims(input byte_item_t it);
    logic [DimW-1:0] seg_len;
    if (it.sof) begin
      phase_q = PH_SOI0;
      skip_left = '0;
      len_hi = '0;
      hdr_idx = '0;
      height_acc_q = '0;
      width_hi = '0;
    end
    if (it.eos) begin
      if (phase_q != PH_DONE) report_dims('0, '0, StatusBad);
    end else begin
      case (phase_q)
        PH_SOI0: begin
          if (it.val != MarkPrefix) report_dims('0, '0, StatusBad);
          else phase_q = PH_SOI1;
        end
        PH_SOI1: begin
          if (it.val != MarkSoi) report_dims('0, '0, StatusBad);
          else phase_q = PH_SEEK;
        end
        PH_SEEK: begin
          if (it.val == MarkPrefix) phase_q = PH_MARK;
        end
        PH_MARK: begin
          if (it.val == MarkPrefix) begin
          end else if (it.val == MarkEoi || it.val == MarkSos) begin
            report_dims('0, '0, StatusBad);
          end else if (frame_code(it.val)) begin
            hdr_idx = '0;
            phase_q = PH_FRAME;
          end else begin
            phase_q = PH_LENHI;
          end
        end
        PH_LENHI: begin
          len_hi = it.val;
          phase_q = PH_LENLO;
        end
        PH_LENLO: begin
          seg_len = {len_hi, it.val};
          if (seg_len < 2) begin
            report_dims('0, '0, StatusBad);
          end else begin
            skip_left = seg_len - 16'd2;
            phase_q = (skip_left == 0) ? PH_SEEK : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (skip_left != 0) skip_left = skip_left - 16'd1;
          if (skip_left == 0) phase_q = PH_SEEK;
        end
        PH_FRAME: begin
          if (hdr_idx == IdxWidthLo) begin
            hdr_idx = '0;
            report_dims({width_hi, it.val}, height_acc_q, StatusOk);
          end else begin
            case (hdr_idx)
              IdxHeightHi: height_acc_q = {it.val, 8'h00};
              IdxHeightLo: height_acc_q = height_acc_q | {8'h00, it.val};
              IdxWidthHi:  width_hi = it.val;
              default: ;
            endcase
            hdr_idx = hdr_idx + 3'd1;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic push_item(input logic [ByteW-1:0] val, input logic sof, input logic eos);
    byte_item_t it;
    it.val = val;
    it.sof = sof;
    it.eos = eos;
    byte_q.push_back(it);
  endtask

  function automatic logic [DimW-1:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return DimW'($urandom);
    endcase
  endfunction

  task automatic gen_file();
    logic [DimW-1:0] seg_len;
    logic [DimW-1:0] dim_h;
    logic [DimW-1:0] dim_w;
    logic [ByteW-1:0] code;
    int nseg;
    int ending;
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(3, 10))
        push_item(ByteW'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
      return;
    end
    if ($urandom_range(0, 19) == 0) begin
      push_item(ByteW'($urandom), 1'b1, 1'b0);
      push_item(ByteW'($urandom), 1'b0, 1'b0);
    end else begin
      push_item(MarkPrefix, 1'b1, 1'b0);
      push_item(MarkSoi, 1'b0, 1'b0);
    end
    nseg = $urandom_range(0, 3);
    repeat (nseg) begin
      repeat ($urandom_range(0, 2)) push_item(ByteW'($urandom_range(0, 254)), 1'b0, 1'b0);
      repeat ($urandom_range(1, 3)) push_item(MarkPrefix, 1'b0, 1'b0);
      do code = ByteW'($urandom);
      while (code == MarkPrefix || code == MarkEoi || code == MarkSos || frame_code(code));
      push_item(code, 1'b0, 1'b0);
      if ($urandom_range(0, 49) == 0) seg_len = DimW'($urandom_range(0, 1));
      else if ($urandom_range(0, 9) == 0) seg_len = DimW'($urandom_range(2, 400));
      else seg_len = DimW'($urandom_range(2, 12));
      push_item(seg_len[15:8], 1'b0, 1'b0);
      push_item(seg_len[7:0], 1'b0, 1'b0);
      if (seg_len < 2) return;
      repeat (seg_len - 2) push_item(ByteW'($urandom), 1'b0, 1'b0);
    end
    ending = $urandom_range(0, 99);
    if (ending < 65) begin
      repeat ($urandom_range(0, 1)) push_item(MarkPrefix, 1'b0, 1'b0);
      push_item(MarkPrefix, 1'b0, 1'b0);
      do code = {SofNibble, 4'($urandom)};
      while (!frame_code(code));
      push_item(code, 1'b0, 1'b0);
      repeat (3) push_item(ByteW'($urandom), 1'b0, 1'b0);
      dim_h = rand_dim();
      dim_w = rand_dim();
      push_item(dim_h[15:8], 1'b0, 1'b0);
      push_item(dim_h[7:0], 1'b0, 1'b0);
      push_item(dim_w[15:8], 1'b0, 1'b0);
      push_item(dim_w[7:0], 1'b0, 1'b0);
      repeat ($urandom_range(0, 2)) push_item(ByteW'($urandom), 1'b0, 1'b0);
      if ($urandom_range(0, 2) == 0) push_item(ByteW'($urandom), 1'b0, 1'b1);
    end else if (ending < 75) begin
      push_item(MarkPrefix, 1'b0, 1'b0);
      push_item($urandom_range(0, 1) ? MarkSos : MarkEoi, 1'b0, 1'b0);
    end else if (ending < 85) begin
      push_item(MarkPrefix, 1'b0, 1'b0);
      push_item({SofNibble, 4'h0}, 1'b0, 1'b0);
      repeat ($urandom_range(0, 6)) push_item(ByteW'($urandom), 1'b0, 1'b0);
      push_item(ByteW'($urandom), 1'b0, 1'b1);
    end else if (ending < 95) begin
      push_item(ByteW'($urandom), $urandom_range(0, 3) == 0, 1'b1);
    end
  endtask

  // stimulus
  initial begin
    // good file: garbage, ordinary C4 segment, fill bytes, SOF2, extremes
    push_item(MarkPrefix, 1'b1, 1'b0);
    push_item(MarkSoi, 1'b0, 1'b0);
    push_item(8'h12, 1'b0, 1'b0);
    push_item(MarkPrefix, 1'b0, 1'b0);
    push_item(MarkDht, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h02, 1'b0, 1'b0);
    push_item(MarkPrefix, 1'b0, 1'b0);
    push_item(MarkPrefix, 1'b0, 1'b0);
    push_item(8'hC2, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h0B, 1'b0, 1'b0);
    push_item(8'h08, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    // ignored after result, then end with nothing pending
    push_item(8'h55, 1'b0, 1'b0);
    push_item(8'hAA, 1'b0, 1'b1);
    // bad first and second signature bytes
    push_item(8'h00, 1'b1, 1'b0);
    push_item(MarkPrefix, 1'b1, 1'b0);
    push_item(MarkEoi, 1'b0, 1'b0);
    // start and end together
    push_item(8'hFF, 1'b1, 1'b1);
    // scan marker
    push_item(MarkPrefix, 1'b1, 1'b0);
    push_item(MarkSoi, 1'b0, 1'b0);
    push_item(MarkPrefix, 1'b0, 1'b0);
    push_item(MarkSos, 1'b0, 1'b0);
    while (byte_q.size() < NumItems) gen_file();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || s_axis_tvalid || dims_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && dims_q.size() == 0) begin
      $display("[jpeg_frame_size_extractor_unit] OK");
    end else begin
      $display("[jpeg_frame_size_extractor_unit] ERROR");
    end
    $finish;
  end

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_dims(cur_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          cur_item = byte_q.pop_front();
          s_axis_tdata <= cur_item.val;
          s_axis_tuser <= {cur_item.eos, cur_item.sof};
          s_axis_tvalid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) hold_cnt <= 0;
    else hold_cnt <= hold_cnt + 1;
  end
  assign hold_off = (hold_cnt >= 300) && (hold_cnt < 700);

  // monitor
  always @(posedge clk_i) begin : mon
    dims_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (dims_q.size() == 0) begin
          $error("unexpected transfer: width %h height %h status %b",
                 m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
          errors = errors + 1;
        end else begin
          want = dims_q.pop_front();
          if (m_axis_tdata[15:0] !== want.w) begin
            $error("width: expected %h, got %h", want.w, m_axis_tdata[15:0]);
            errors = errors + 1;
          end
          if (m_axis_tdata[31:16] !== want.h) begin
            $error("height: expected %h, got %h", want.h, m_axis_tdata[31:16]);
            errors = errors + 1;
          end
          if (m_axis_tuser !== want.st) begin
            $error("status: expected %b, got %b", want.st, m_axis_tuser);
            errors = errors + 1;
          end
        end
      end
      if (stall_timer == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
        stall_timer = $urandom_range(20, 200);
      end else begin
        stall_timer = stall_timer - 1;
      end
      m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("[jpeg_frame_size_extractor_unit] ERROR");
      $finish;
    end
  end

endmodule
